// ===== src/pica_pkg.sv =====
package pica_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [16:0] err_t;
  typedef logic signed [31:0] acc_t;
  typedef logic [1:0]         reg_idx_t;

  localparam int unsigned SHIFT_P = 2;
  localparam int unsigned SHIFT_I = 8;

  localparam reg_idx_t REG_PROP_GAIN  = 2'd0;
  localparam reg_idx_t REG_INTEG_GAIN = 2'd1;
  localparam reg_idx_t REG_OUT_MAX    = 2'd2;
  localparam reg_idx_t REG_OUT_MIN    = 2'd3;

  localparam sample_t PROP_GAIN_RST  = 16'sd0;
  localparam sample_t INTEG_GAIN_RST = 16'sd0;
  localparam sample_t OUT_MAX_RST    = 16'sh7fff;
  localparam sample_t OUT_MIN_RST    = 16'sh8000;

endpackage

// ===== src/pica_if.sv =====
interface pica_in_if;
  import pica_pkg::*;

  logic    valid;
  logic    ready;
  sample_t reference;
  sample_t measured;

  modport source (output valid, output reference, output measured, input ready);
  modport sink   (input valid, input reference, input measured, output ready);
endinterface

interface pica_out_if;
  import pica_pkg::*;

  logic    valid;
  logic    ready;
  sample_t drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== src/pica_clamp.sv =====
module pica_clamp (
  input  pica_pkg::acc_t    p_term,
  input  pica_pkg::acc_t    i_inc,
  input  logic              ki_nz,
  input  pica_pkg::acc_t    integ,
  input  pica_pkg::sample_t out_max,
  input  pica_pkg::sample_t out_min,
  output pica_pkg::sample_t drive,
  output pica_pkg::acc_t    integ_nxt
);
  import pica_pkg::*;

  acc_t i_term;
  acc_t i_hi;
  acc_t sum;
  acc_t sum_hi;
  acc_t sum_lo;
  acc_t max_ext;
  acc_t min_ext;

  always_comb begin
    max_ext = acc_t'(out_max);
    min_ext = acc_t'(out_min);
    i_term  = ki_nz ? acc_t'(i_inc + integ) : '0;
    sum     = acc_t'(p_term + i_term);

    // upper limit first, the lower limit then sees the clamped sum
    sum_hi = sum;
    i_hi   = i_term;
    if (sum > max_ext) begin
      sum_hi = max_ext;
      if (i_term > integ) i_hi = integ;
    end

    sum_lo    = sum_hi;
    integ_nxt = i_hi;
    if (sum_hi < min_ext) begin
      sum_lo = min_ext;
      if (i_hi < integ) integ_nxt = integ;
    end

    drive = sample_t'(sum_lo[15:0]);
  end

endmodule

// ===== src/pi_controller_antiwindup.sv =====
// datapath: a transaction passes the error, products and clamp registers in turn;
// throughput: one transaction per cycle while out_chan.ready does not stall; every
// stage has its own valid bit and the integrator recurrence (add, add, compare)
// closes within the last stage alone
// reset: synchronous active-low rst_n clears all valid bits and the integrator and
// loads the gain and limit registers with their defaults
module pi_controller_antiwindup (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  pica_pkg::reg_idx_t  cfg_idx,
  input  pica_pkg::sample_t   cfg_data,
  pica_in_if.sink             in_chan,
  pica_out_if.source          out_chan
);
  import pica_pkg::*;

  // configuration registers
  sample_t prop_gain_r, integ_gain_r, out_max_r, out_min_r;

  // stage 1: error
  logic    v1_r;
  err_t    err_r;
  // stage 2: scaled products
  logic    v2_r;
  acc_t    p_term_r;
  acc_t    i_inc_r;
  logic    ki_nz_r;
  // stage 3: result register and loop state
  logic    out_valid_r;
  sample_t drive_r;
  acc_t    integ_r;

  logic    take3, ready2, ready1;
  err_t    err_nxt;
  logic signed [32:0] p_prod, i_prod;
  acc_t    p_term_nxt, i_inc_nxt;
  sample_t drive_nxt;
  acc_t    integ_nxt;

  // per-stage flow control, a stage refills when it empties downstream
  assign take3  = !out_valid_r || out_chan.ready;
  assign ready2 = !v2_r || take3;
  assign ready1 = !v1_r || ready2;
  assign in_chan.ready = ready1;

  assign out_chan.valid = out_valid_r;
  assign out_chan.drive = drive_r;

  // config write port, user writes only while the pipeline is empty; not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      out_max_r    <= OUT_MAX_RST;
      out_min_r    <= OUT_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_data;
        REG_INTEG_GAIN: integ_gain_r <= cfg_data;
        REG_OUT_MAX:    out_max_r    <= cfg_data;
        REG_OUT_MIN:    out_min_r    <= cfg_data;
        default:        prop_gain_r  <= prop_gain_r;
      endcase
    end
  end

  // error is held exactly in 17 bits
  assign err_nxt = err_t'(err_t'(in_chan.reference) - err_t'(in_chan.measured));

  // products wrap to 32 bits before the arithmetic shift
  always_comb begin
    p_prod     = prop_gain_r * err_r;
    i_prod     = integ_gain_r * err_r;
    p_term_nxt = $signed(p_prod[31:0]) >>> SHIFT_P;
    i_inc_nxt  = $signed(i_prod[31:0]) >>> SHIFT_I;
  end

  pica_clamp u_clamp (
    .p_term    (p_term_r),
    .i_inc     (i_inc_r),
    .ki_nz     (ki_nz_r),
    .integ     (integ_r),
    .out_max   (out_max_r),
    .out_min   (out_min_r),
    .drive     (drive_nxt),
    .integ_nxt (integ_nxt)
  );

  // valid bits and integrator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
    end else begin
      if (ready1) v1_r <= in_chan.valid;
      if (ready2) v2_r <= v1_r;
      if (take3)  out_valid_r <= v2_r;
      // integrator moves only when its transaction reaches the result register
      if (take3 && v2_r) integ_r <= integ_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (ready1 && in_chan.valid) err_r <= err_nxt;
    if (ready2 && v1_r) begin
      p_term_r <= p_term_nxt;
      i_inc_r  <= i_inc_nxt;
      ki_nz_r  <= (integ_gain_r != '0);
    end
    if (take3 && v2_r) drive_r <= drive_nxt;
  end

  // integrator holds unless a transaction leaves the clamp stage
  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(take3 && v2_r) |=> $stable(integ_r))
    else $error("integrator changed without a transaction");

  // zero integral gain gives either a cleared or a restored integrator
  a_ki_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take3 && v2_r && !ki_nz_r) |=> (integ_r == '0 || integ_r == $past(integ_r)))
    else $error("integrator moved with zero integral gain");

  // full and stalled pipeline takes no new transaction
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted into a full pipeline");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

// ===== bench/pi_controller_antiwindup_tb.sv =====
module pi_controller_antiwindup_tb;
  import pica_pkg::*;

  // three-stage pipeline in the block, plus some margin for the pause and the end
  localparam int PIPE_LATENCY   = 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_SAMPLES = 400;

  typedef struct {
    sample_t reference;
    sample_t measured;
  } sample_pair_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  reg_idx_t cfg_idx;
  sample_t  cfg_data;

  pica_in_if  in_chan();
  pica_out_if out_chan();

  pi_controller_antiwindup dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // controller state mirrored in the bench: gains, limits and integrator
  sample_t kp;
  sample_t ki;
  sample_t lim_hi;
  sample_t lim_lo;
  acc_t    integ_acc;

  // samples waiting to be sent and drive values waiting to come back
  sample_pair_t sample_queue[$];
  sample_t      expected_drive[$];
  sample_pair_t next_pair;

  int  samples_queued;
  int  samples_taken;
  int  failures;
  int  quiet_cycles;
  int  send_idle_pct;
  int  stall_pct;
  logic in_taken;

  always #2 clk = ~clk;

  // one control step: error, P and I terms, clamp with anti-windup on the integrator
  function automatic sample_t predict_drive(sample_t target, sample_t actual);
    err_t               err;
    logic signed [32:0] p_prod;
    logic signed [32:0] i_prod;
    acc_t               p_term;
    acc_t               i_term;
    acc_t               sum;
    acc_t               old_i;
    err    = err_t'(target) - err_t'(actual);
    p_prod = kp * err;
    i_prod = ki * err;
    p_term = $signed(p_prod[31:0]) >>> SHIFT_P;
    i_term = '0;
    if (ki != 0)
      i_term = ($signed(i_prod[31:0]) >>> SHIFT_I) + integ_acc;
    sum   = p_term + i_term;
    old_i = integ_acc;
    // upper clamp first: integrator may only stay or move down
    if (sum > lim_hi) begin
      sum = acc_t'(lim_hi);
      if (i_term > old_i) i_term = old_i;
    end
    // lower clamp on the possibly clamped sum, so inverted limits give lim_lo
    if (sum < lim_lo) begin
      sum = acc_t'(lim_lo);
      if (i_term < old_i) i_term = old_i;
    end
    integ_acc = i_term;
    return sum[15:0];
  endfunction

  function automatic sample_t pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3: return sample_t'($urandom_range(4095)) - 16'sd2048;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // input driver: a new transaction only when the lane is free or the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_pair = sample_queue.pop_front();
        in_chan.valid     <= 1'b1;
        in_chan.reference <= next_pair.reference;
        in_chan.measured  <= next_pair.measured;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // monitor: check drive results against the oldest prediction, then predict new samples
  always @(posedge clk) begin
    sample_t want;
    in_taken <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_drive.size() == 0) begin
        $error("drive: unexpected result %0d", out_chan.drive);
        failures++;
      end else begin
        want = expected_drive.pop_front();
        if (out_chan.drive !== want) begin
          $error("drive mismatch: expected %0d, actual %0d", want, out_chan.drive);
          failures++;
        end
      end
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      expected_drive.push_back(predict_drive(in_chan.reference, in_chan.measured));
      samples_taken++;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else if (rst_n)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pi_controller_antiwindup_tb NOT OK");
      $finish;
    end
  end

  task automatic queue_sample(sample_t target, sample_t actual);
    sample_pair_t pair;
    pair.reference = target;
    pair.measured  = actual;
    sample_queue.push_back(pair);
    samples_queued++;
  endtask

  // wait until every sample is taken and checked, then let the pipeline settle
  task automatic wait_idle();
    while (samples_taken != samples_queued || expected_drive.size() != 0)
      @(negedge clk);
    repeat (PIPE_LATENCY + 1) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, sample_t val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
  endtask

  // only called with the block idle, so the mirror can follow right away
  task automatic load_settings(sample_t p, sample_t i, sample_t hi, sample_t lo);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_OUT_MIN, lo);
    @(negedge clk);
    cfg_we <= 1'b0;
    kp     = p;
    ki     = i;
    lim_hi = hi;
    lim_lo = lo;
  endtask

  // random content shaped like a control loop: mostly tracking runs and windup bursts
  task automatic queue_random_samples(int count);
    int      n;
    int      kind;
    int      len;
    sample_t base;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(9);
      len  = $urandom_range(12, 3);
      base = sample_t'($urandom);
      for (int k = 0; k < len && n < count; k++) begin
        if (kind < 6)
          queue_sample(base, base + sample_t'($urandom_range(511)) - 16'sd256);
        else if (kind < 8)
          queue_sample(base[0] ? 16'sh7fff : 16'sh8000, base[0] ? 16'sh8000 : 16'sh7fff);
        else
          queue_sample(sample_t'($urandom), sample_t'($urandom));
        n++;
      end
    end
  endtask

  task automatic load_random_settings();
    sample_t a;
    sample_t b;
    sample_t hi;
    sample_t lo;
    a = sample_t'($urandom);
    b = sample_t'($urandom);
    case ($urandom_range(4))
      0: begin
        hi = 16'sh7fff;
        lo = 16'sh8000;
      end
      1: begin
        hi = (a >= b) ? a : b;
        lo = (a >= b) ? b : a;
      end
      2: begin
        // inverted limits
        hi = (a >= b) ? b : a;
        lo = (a >= b) ? a : b;
      end
      3: begin
        hi = sample_t'($urandom_range(2000));
        lo = -sample_t'($urandom_range(2000));
      end
      default: begin
        hi = a;
        lo = a;
      end
    endcase
    load_settings(pick_gain(), pick_gain(), hi, lo);
  endtask

  initial begin
    int phase;
    int sent_random;
    int len;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_PROP_GAIN;
    cfg_data       = '0;
    in_chan.valid     = 1'b0;
    in_chan.reference = '0;
    in_chan.measured  = '0;
    out_chan.ready    = 1'b0;
    in_taken       = 1'b0;
    samples_queued = 0;
    samples_taken  = 0;
    failures       = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    kp             = PROP_GAIN_RST;
    ki             = INTEG_GAIN_RST;
    lim_hi         = OUT_MAX_RST;
    lim_lo         = OUT_MIN_RST;
    integ_acc      = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults after reset: both gains zero, drive stays zero
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'sh8000, 16'sh7fff);
    queue_sample(16'sd0, 16'sd0);
    wait_idle();

    // full gains against narrow limits: upper and lower clamp, integrator held
    load_settings(16'sh7fff, 16'sh7fff, 16'sd1000, -16'sd1000);
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'sh8000, 16'sh7fff);
    queue_sample(16'sd0, 16'sd0);
    queue_sample(16'sd5, 16'sd3);
    queue_sample(-16'sd5, 16'sd3);
    queue_sample(16'sh7fff, 16'sh7fff);
    queue_sample(16'sh8000, 16'sh8000);
    wait_idle();

    // inverted limits: result always sits at the lower limit
    load_settings(16'sd100, -16'sd300, -16'sd500, 16'sd500);
    queue_sample(16'sd1000, 16'sd0);
    queue_sample(-16'sd1000, 16'sd0);
    queue_sample(16'sd0, 16'sd0);
    queue_sample(16'sh8000, 16'sh7fff);
    wait_idle();

    // integral gain zero after some windup, most negative proportional gain
    load_settings(16'sh8000, 16'sd0, 16'sh7fff, 16'sh8000);
    queue_sample(16'sd1, 16'sd0);
    queue_sample(16'sd0, 16'sd1);
    queue_sample(16'sh8000, 16'sh7fff);
    queue_sample(16'sh7fff, 16'sh8000);
    wait_idle();

    // smallest nonzero gains, full range
    load_settings(16'sd1, 16'sd1, 16'sh7fff, 16'sh8000);
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'sh8000, 16'sh7fff);
    queue_sample(16'sd3, 16'sd0);
    wait_idle();

    // random part: new settings each phase, idle pattern rotating through four modes
    phase       = 0;
    sent_random = 0;
    while (sent_random < RANDOM_SAMPLES) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 63;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 63;
        end
        default: begin
          send_idle_pct = 33;
          stall_pct     = 33;
        end
      endcase
      load_random_settings();
      len = $urandom_range(40, 15);
      queue_random_samples(len);
      sent_random += len;
      wait_idle();
      phase++;
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    wait_idle();
    repeat (4 * PIPE_LATENCY) @(negedge clk);
    if (failures == 0 && expected_drive.size() == 0)
      $display("pi_controller_antiwindup_tb OK");
    else
      $display("pi_controller_antiwindup_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
src/pica_pkg.sv
src/pica_if.sv
src/pica_clamp.sv
src/pi_controller_antiwindup.sv
bench/pi_controller_antiwindup_tb.sv
